[hdl/rms_pkg.sv]
// shared constants and types for the range multilateration solver
`default_nettype none
package rms_pkg;
   localparam int MAX_ANCHORS = 8;
   localparam int ANCHOR_AW = $clog2(MAX_ANCHORS);
   localparam int ANCHOR_CW = $clog2(MAX_ANCHORS + 1);

   localparam int POS_W = 32;
   localparam int RANGE_W = 31;
   localparam int WEIGHT_W = 16;
   localparam int ENTRY_W = 2 * POS_W + RANGE_W + 1 + WEIGHT_W;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_STEP_GAIN      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_STOP_THRESHOLD = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_START_X        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_START_Y        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_ITERATIONS = 3'd4;

   localparam logic [15:0] STEP_GAIN_RESET      = 16'd655;
   localparam logic [15:0] STOP_THRESHOLD_RESET = 16'd66;
   localparam logic [31:0] START_X_RESET        = 32'd655360;
   localparam logic [31:0] START_Y_RESET        = 32'd655360;
   localparam logic [15:0] MAX_ITERATIONS_RESET = 16'd4096;

   typedef struct packed {
      logic signed [POS_W-1:0] anchor_x;
      logic signed [POS_W-1:0] anchor_y;
      logic [RANGE_W-1:0]      measured_range;
      logic                    range_valid;
      logic [WEIGHT_W-1:0]     anchor_weight;
   } entry_type;

   typedef enum logic [19:0] {
      ST_IDLE     = 20'h00001,
      ST_ITER     = 20'h00002,
      ST_RD       = 20'h00004,
      ST_DIFF     = 20'h00008,
      ST_SQX      = 20'h00010,
      ST_SQY      = 20'h00020,
      ST_SQRT_LD  = 20'h00040,
      ST_SQRT     = 20'h00080,
      ST_DIST     = 20'h00100,
      ST_MUL_E    = 20'h00200,
      ST_DIV_LD   = 20'h00400,
      ST_DIV      = 20'h00800,
      ST_MUL_W    = 20'h01000,
      ST_ACC      = 20'h02000,
      ST_NEXT     = 20'h04000,
      ST_STEP_LO  = 20'h08000,
      ST_STEP_HI  = 20'h10000,
      ST_STEP_SUM = 20'h20000,
      ST_UPDATE   = 20'h40000,
      ST_DONE     = 20'h80000
   } state_type;
endpackage
`default_nettype wire

[hdl/rms_ram.sv]
// generic single write port ram with registered read
`default_nettype none
module rms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[hdl/range_multilateration_solver.sv]
// top level: anchor store and iterative gradient descent sequencer
// Anchor items are taken one per cycle while busy is low; an item with last_anchor set
// starts the solve and busy stays high until the result strobe. Each descent iteration
// runs each valid anchor through the shared 33x33 multiplier, the one-bit-per-cycle
// square root (32 steps) and the restoring divider (64 steps per axis); invalid anchors
// are skipped.
// The result is shown for one cycle on rsp_valid and cannot be held off by the receiver.
`default_nettype none
module range_multilateration_solver (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic signed [31:0]               req_anchor_x,
   input  wire logic signed [31:0]               req_anchor_y,
   input  wire logic [30:0]                      req_measured_range,
   input  wire logic                             req_range_valid,
   input  wire logic [15:0]                      req_anchor_weight,
   input  wire logic                             req_last_anchor,
   output logic                                  rsp_valid,
   output logic signed [31:0]                    rsp_pos_x,
   output logic signed [31:0]                    rsp_pos_y,
   output logic [15:0]                           rsp_iteration_count,
   output logic                                  rsp_converged,
   input  wire logic                             csr_write_enable,
   input  wire logic [rms_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [rms_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import rms_pkg::*;

   state_type state_ff, state_in;
   logic [ANCHOR_CW-1:0] count_ff, count_in;
   logic [ANCHOR_AW-1:0] idx_ff, idx_in;
   logic axis_ff, axis_in;
   logic [15:0] iter_ff, iter_in;
   logic signed [31:0] est_x_ff, est_x_in, est_y_ff, est_y_in;
   logic signed [47:0] sx_ff, sx_in, sy_ff, sy_in;
   logic signed [47:0] stx_ff, stx_in, sty_ff, sty_in;
   logic [31:0] ax_ff, ax_in, ay_ff, ay_in;
   logic xneg_ff, xneg_in, yneg_ff, yneg_in, eneg_ff, eneg_in;
   logic [30:0] range_ff, range_in;
   logic [15:0] weight_ff, weight_in;
   logic [63:0] prod_ff, prod_in, sq_ff, sq_in;
   logic [63:0] rad_ff, rad_in, res_ff, res_in, bit_ff, bit_in;
   logic [31:0] dist_ff, dist_in;
   logic [32:0] ae_ff, ae_in;
   logic [63:0] num_ff, num_in;
   logic [31:0] rem_ff, rem_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [47:0] lo_ff, lo_in;
   logic conv_ff, conv_in;

   logic [15:0] gain_ff, thr_ff, maxit_ff;
   logic signed [31:0] startx_ff, starty_ff;

   logic rsp_valid_ff;
   logic signed [31:0] rsp_x_ff, rsp_y_ff;
   logic [15:0] rsp_iter_ff;
   logic rsp_conv_ff;

   logic accept;
   logic wr_en;
   entry_type wr_entry, rd_entry;
   logic [ENTRY_W-1:0] rd_bits;

   logic [32:0] mul_a, mul_b;
   logic [65:0] mul_p;

   assign accept = start && !busy;
   assign busy = (state_ff != ST_IDLE);
   assign wr_en = accept && (count_ff < ANCHOR_CW'(MAX_ANCHORS));
   assign wr_entry = '{anchor_x: req_anchor_x, anchor_y: req_anchor_y,
                       measured_range: req_measured_range, range_valid: req_range_valid,
                       anchor_weight: req_anchor_weight};
   assign rd_entry = entry_type'(rd_bits);

   rms_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ANCHORS)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ANCHOR_AW-1:0]),
      .wr_data (wr_entry),
      .rd_addr (idx_ff),
      .rd_data (rd_bits)
   );

   function automatic logic signed [31:0] clamp32(input logic signed [48:0] v);
      if (v > 49'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -49'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic [47:0] abs48(input logic signed [47:0] v);
      return v[47] ? 48'(-v) : 48'(v);
   endfunction

   // shared multiplier
   logic [46:0] gmag;
   assign gmag = 47'(abs48(axis_ff ? sy_ff : sx_ff));
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SQX: begin
            mul_a = {1'b0, ax_ff};
            mul_b = {1'b0, ax_ff};
         end
         ST_SQY: begin
            mul_a = {1'b0, ay_ff};
            mul_b = {1'b0, ay_ff};
         end
         ST_DIV_LD: begin
            mul_a = {1'b0, axis_ff ? ay_ff : ax_ff};
            mul_b = ae_ff;
         end
         ST_MUL_W: begin
            mul_a = num_ff[32:0];
            mul_b = {17'd0, weight_ff};
         end
         ST_STEP_LO: begin
            mul_a = {1'b0, gmag[31:0]};
            mul_b = {17'd0, gain_ff};
         end
         ST_STEP_HI: begin
            mul_a = {18'd0, gmag[46:32]};
            mul_b = {17'd0, gain_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   logic signed [32:0] dfx, dfy;
   logic signed [31:0] dxc, dyc;
   logic [63:0] sq_try;
   logic [32:0] div_sh;
   logic signed [33:0] e_full;
   logic [41:0] term;
   logic signed [48:0] acc_sum;
   logic signed [47:0] acc_base;
   logic [63:0] step_total;
   logic [46:0] step_mag;
   logic [15:0] cap;

   always_comb begin
      dfx = 33'(est_x_ff) - 33'(rd_entry.anchor_x);
      dfy = 33'(est_y_ff) - 33'(rd_entry.anchor_y);
      dxc = clamp32(49'(dfx));
      dyc = clamp32(49'(dfy));
      sq_try = res_ff + bit_ff;
      div_sh = {rem_ff, num_ff[63]};
      e_full = 34'($signed({2'b00, dist_ff})) - 34'($signed({3'b000, range_ff}));
      term = prod_ff[48:7];
      acc_base = axis_ff ? sy_ff : sx_ff;
      if ((axis_ff ? yneg_ff : xneg_ff) ^ eneg_ff) begin
         acc_sum = 49'(acc_base) - $signed({7'd0, term});
      end else begin
         acc_sum = 49'(acc_base) + $signed({7'd0, term});
      end
      if (acc_sum > 49'sd70368744177664) begin
         acc_sum = 49'sd70368744177664;
      end else if (acc_sum < -49'sd70368744177664) begin
         acc_sum = -49'sd70368744177664;
      end
      step_total = {prod_ff[31:0], 32'd0} + {16'd0, lo_ff};
      step_mag = step_total[62:16];
      cap = (maxit_ff == 16'd0) ? 16'd1 : maxit_ff;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      axis_in = axis_ff;
      iter_in = iter_ff;
      est_x_in = est_x_ff;
      est_y_in = est_y_ff;
      sx_in = sx_ff;
      sy_in = sy_ff;
      stx_in = stx_ff;
      sty_in = sty_ff;
      ax_in = ax_ff;
      ay_in = ay_ff;
      xneg_in = xneg_ff;
      yneg_in = yneg_ff;
      eneg_in = eneg_ff;
      range_in = range_ff;
      weight_in = weight_ff;
      prod_in = prod_ff;
      sq_in = sq_ff;
      rad_in = rad_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      dist_in = dist_ff;
      ae_in = ae_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      lo_in = lo_ff;
      conv_in = conv_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (wr_en) begin
                  count_in = count_ff + ANCHOR_CW'(1);
               end
               if (req_last_anchor) begin
                  est_x_in = startx_ff;
                  est_y_in = starty_ff;
                  iter_in = '0;
                  conv_in = 1'b0;
                  state_in = ST_ITER;
               end
            end
         end
         ST_ITER: begin
            iter_in = iter_ff + 16'd1;
            sx_in = '0;
            sy_in = '0;
            idx_in = '0;
            axis_in = 1'b0;
            state_in = (count_ff == '0) ? ST_STEP_LO : ST_RD;
         end
         ST_RD: begin
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            ax_in = dxc[31] ? 32'(-33'(dxc)) : 32'(dxc);
            ay_in = dyc[31] ? 32'(-33'(dyc)) : 32'(dyc);
            xneg_in = dxc[31];
            yneg_in = dyc[31];
            range_in = rd_entry.measured_range;
            weight_in = rd_entry.anchor_weight;
            state_in = rd_entry.range_valid ? ST_SQX : ST_NEXT;
         end
         ST_SQX: begin
            prod_in = mul_p[63:0];
            state_in = ST_SQY;
         end
         ST_SQY: begin
            sq_in = prod_ff;
            prod_in = mul_p[63:0];
            state_in = ST_SQRT_LD;
         end
         ST_SQRT_LD: begin
            rad_in = sq_ff + prod_ff;
            res_in = '0;
            bit_in = 64'd1 << 62;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (rad_ff >= sq_try) begin
               rad_in = rad_ff - sq_try;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               state_in = ST_DIST;
            end
         end
         ST_DIST: begin
            dist_in = res_ff[31:0];
            state_in = (res_ff[31:0] == 32'd0) ? ST_NEXT : ST_MUL_E;
         end
         ST_MUL_E: begin
            if (axis_ff == 1'b0) begin
               eneg_in = e_full[33];
               ae_in = e_full[33] ? 33'(-e_full) : 33'(e_full);
            end
            state_in = ST_DIV_LD;
         end
         ST_DIV_LD: begin
            num_in = mul_p[63:0];
            rem_in = '0;
            cnt_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_sh >= {1'b0, dist_ff}) begin
               rem_in = 32'(div_sh - {1'b0, dist_ff});
               num_in = {num_ff[62:0], 1'b1};
            end else begin
               rem_in = div_sh[31:0];
               num_in = {num_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = ST_MUL_W;
            end
         end
         ST_MUL_W: begin
            prod_in = mul_p[63:0];
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (axis_ff) begin
               sy_in = acc_sum[47:0];
               axis_in = 1'b0;
               state_in = ST_NEXT;
            end else begin
               sx_in = acc_sum[47:0];
               axis_in = 1'b1;
               state_in = ST_MUL_E;
            end
         end
         ST_NEXT: begin
            idx_in = idx_ff + ANCHOR_AW'(1);
            axis_in = 1'b0;
            if (ANCHOR_CW'(idx_ff) + ANCHOR_CW'(1) == count_ff) begin
               state_in = ST_STEP_LO;
            end else begin
               state_in = ST_RD;
            end
         end
         ST_STEP_LO: begin
            prod_in = mul_p[63:0];
            state_in = ST_STEP_HI;
         end
         ST_STEP_HI: begin
            lo_in = prod_ff[47:0];
            prod_in = mul_p[63:0];
            state_in = ST_STEP_SUM;
         end
         ST_STEP_SUM: begin
            if (axis_ff) begin
               sty_in = sy_ff[47] ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});
               axis_in = 1'b0;
               state_in = ST_UPDATE;
            end else begin
               stx_in = sx_ff[47] ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});
               axis_in = 1'b1;
               state_in = ST_STEP_LO;
            end
         end
         ST_UPDATE: begin
            if (abs48(stx_ff) < {32'd0, thr_ff} && abs48(sty_ff) < {32'd0, thr_ff}) begin
               conv_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               est_x_in = clamp32(49'(est_x_ff) - 49'(stx_ff));
               est_y_in = clamp32(49'(est_y_ff) - 49'(sty_ff));
               state_in = (iter_ff >= cap) ? ST_DONE : ST_ITER;
            end
         end
         ST_DONE: begin
            count_in = '0;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         est_x_ff <= '0;
         est_y_ff <= '0;
         rsp_valid_ff <= 1'b0;
         gain_ff <= STEP_GAIN_RESET;
         thr_ff <= STOP_THRESHOLD_RESET;
         startx_ff <= START_X_RESET;
         starty_ff <= START_Y_RESET;
         maxit_ff <= MAX_ITERATIONS_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         est_x_ff <= est_x_in;
         est_y_ff <= est_y_in;
         rsp_valid_ff <= (state_ff == ST_DONE);
         if (csr_write_enable) begin
            case (csr_index)
               REG_STEP_GAIN:      gain_ff <= csr_write_data[15:0];
               REG_STOP_THRESHOLD: thr_ff <= csr_write_data[15:0];
               REG_START_X:        startx_ff <= csr_write_data;
               REG_START_Y:        starty_ff <= csr_write_data;
               REG_MAX_ITERATIONS: maxit_ff <= csr_write_data[15:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      axis_ff <= axis_in;
      iter_ff <= iter_in;
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      stx_ff <= stx_in;
      sty_ff <= sty_in;
      ax_ff <= ax_in;
      ay_ff <= ay_in;
      xneg_ff <= xneg_in;
      yneg_ff <= yneg_in;
      eneg_ff <= eneg_in;
      range_ff <= range_in;
      weight_ff <= weight_in;
      prod_ff <= prod_in;
      sq_ff <= sq_in;
      rad_ff <= rad_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      dist_ff <= dist_in;
      ae_ff <= ae_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      lo_ff <= lo_in;
      conv_ff <= conv_in;
      if (state_ff == ST_DONE) begin
         rsp_x_ff <= est_x_ff;
         rsp_y_ff <= est_y_ff;
         rsp_iter_ff <= iter_ff;
         rsp_conv_ff <= conv_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = rsp_x_ff;
   assign rsp_pos_y = rsp_y_ff;
   assign rsp_iteration_count = rsp_iter_ff;
   assign rsp_converged = rsp_conv_ff;
endmodule
`default_nettype wire
